// ===== hw/rtl/tilt_estimate_and_pid_macros.svh =====
// Assertion macros shared by the tilt estimator RTL
`ifndef TILT_ESTIMATE_AND_PID_MACROS_SVH
`define TILT_ESTIMATE_AND_PID_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication on clk_i, off during reset
`define TEP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication on clk_i, off during reset
`define TEP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TEP_ASSERT_IMP(lbl, ante, cons, msg)
`define TEP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tep_pkg.sv =====
// Package: codes, constants and saturation helper for the tilt estimator
package tep_pkg;

  // Accelerometer sample at zero tilt
  localparam logic [15:0] ACCEL_OFFSET = 16'd32768;

  // Reset value of the angle integral: 1400.0 in Q16.16
  localparam logic signed [31:0] INTEGRAL_RESET = 32'sd91750400;

  // Reset values of the configuration registers
  localparam logic [15:0]        GYRO_ZERO_RESET = 16'd32768;
  localparam logic signed [31:0] UNITY_GAIN      = 32'sd65536;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_GYRO_ZERO  = 3'd0,
    CFG_ACCEL_GAIN = 3'd1,
    CFG_GYRO_GAIN  = 3'd2,
    CFG_BLEND_GAIN = 3'd3,
    CFG_SETPOINT   = 3'd4,
    CFG_KP         = 3'd5,
    CFG_KI         = 3'd6,
    CFG_KD         = 3'd7
  } cfg_idx_e;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_STEP      = 2'd0,
    OP_RESET_PID = 2'd1,
    OP_ALIGN     = 2'd2,
    OP_HOLD      = 2'd3
  } op_e;

  // Clamp a 64-bit signed value to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic fits;
    fits = (&x[63:31]) || (~|x[63:31]);
    if (fits) begin
      return x[31:0];
    end else if (x[63]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

endpackage

// ===== hw/rtl/tep_if.sv =====
// Valid/ready channel interfaces for input items and result items
interface tep_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] accel_sample;
  logic [15:0] gyro_sample;

  modport source (output valid, output operation, output accel_sample,
                  output gyro_sample, input ready);
  modport sink   (input valid, input operation, input accel_sample,
                  input gyro_sample, output ready);
endinterface

interface tep_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic signed [31:0] tilt_angle;
  logic signed [31:0] angle_error;

  modport source (output valid, output drive, output tilt_angle,
                  output angle_error, input ready);
  modport sink   (input valid, input drive, input tilt_angle,
                  input angle_error, output ready);
endinterface

// ===== hw/rtl/tilt_estimate_and_pid.sv =====
// Top level: complementary tilt filter and incremental PID on one shared multiplier
// A control step runs S_MUL_ACC through S_SAT, align ends after S_ANGLE, PID reset/hold go to S_DONE.
// One item at a time: a new item is taken once the sequencer is back in idle, even while the last
// result still waits in the output register.
// All products go through a single registered 32x32 signed multiplier, one per cycle.
// Reset: asynchronous, active low; state registers take their reset values, integral 1400.0.
`include "tilt_estimate_and_pid_macros.svh"

module tilt_estimate_and_pid (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  tep_in_if.sink      in_if,
  tep_out_if.source   out_if
);
  import tep_pkg::*;

  localparam int unsigned AccW = 56;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_ACC,
    S_ANGLE,
    S_DIFF,
    S_MUL_BLEND,
    S_BLEND,
    S_UPDATE,
    S_ACC_I,
    S_ACC_D,
    S_SAT,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [15:0]        gyro_zero_q;
  logic signed [31:0] accel_gain_q, gyro_gain_q, blend_gain_q;
  logic signed [15:0] setpoint_q;
  logic signed [31:0] kp_q, ki_q, kd_q;

  // estimator and PID state
  logic signed [31:0] integral_q;
  logic signed [31:0] kp_l_q, ki_l_q, kd_l_q;
  logic signed [17:0] e1_q, e2_q;
  logic signed [31:0] drive_last_q;

  // item and working registers
  op_e                op_q;
  logic [15:0]        accel_q, gyro_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] accel_angle_q, rate_q, diff_q, blend_q;
  logic signed [17:0] err_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [31:0] res_drive_q, res_tilt_q, res_err_q;

  // output register
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_drive_q, out_tilt_q, out_err_q;

  logic               in_accept, load_out;
  logic signed [31:0] mul_a, mul_b;
  logic signed [16:0] accel_dev, gyro_dev, whole;
  logic               round_up;
  logic signed [17:0] err_new;
  logic signed [18:0] d1;
  logic signed [19:0] d2;
  logic signed [31:0] drive_sat;

  assign in_if.ready       = (state_q == S_IDLE);
  assign in_accept         = in_if.valid && in_if.ready;
  assign load_out          = !out_valid_q || out_if.ready;
  assign out_if.valid      = out_valid_q;
  assign out_if.drive      = out_drive_q;
  assign out_if.tilt_angle = out_tilt_q;
  assign out_if.angle_error = out_err_q;

  // sample deviations, both 17-bit signed
  assign accel_dev = signed'({1'b0, accel_q}) - signed'({1'b0, ACCEL_OFFSET});
  assign gyro_dev  = signed'({1'b0, gyro_zero_q}) - signed'({1'b0, gyro_q});

  // integer part of the integral, truncated toward zero
  assign round_up = integral_q[31] && (|integral_q[15:0]);
  assign whole    = 17'(signed'(integral_q[31:16])) + 17'(round_up);
  assign err_new  = 18'(whole) - 18'(setpoint_q);

  // PID in difference form: kp*(e0-e1) + ki*e0 + kd*(e0-2e1+e2)
  assign d1 = 19'(err_q) - 19'(e1_q);
  assign d2 = 20'(err_q) - (20'(e1_q) <<< 1) + 20'(e2_q);

  assign drive_sat = sat32(64'(acc_q));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL_ACC: begin
        mul_a = accel_gain_q;
        mul_b = 32'(accel_dev);
      end
      S_ANGLE: begin
        mul_a = gyro_gain_q;
        mul_b = 32'(gyro_dev);
      end
      S_MUL_BLEND: begin
        mul_a = blend_gain_q;
        mul_b = diff_q;
      end
      S_BLEND: begin
        mul_a = kp_l_q;
        mul_b = 32'(d1);
      end
      S_UPDATE: begin
        mul_a = ki_l_q;
        mul_b = 32'(err_q);
      end
      S_ACC_I: begin
        mul_a = kd_l_q;
        mul_b = 32'(d2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (in_if.operation == OP_STEP || in_if.operation == OP_ALIGN) begin
            state_d = S_MUL_ACC;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_MUL_ACC:   state_d = S_ANGLE;
      S_ANGLE:     state_d = (op_q == OP_ALIGN) ? S_DONE : S_DIFF;
      S_DIFF:      state_d = S_MUL_BLEND;
      S_MUL_BLEND: state_d = S_BLEND;
      S_BLEND:     state_d = S_UPDATE;
      S_UPDATE:    state_d = S_ACC_I;
      S_ACC_I:     state_d = S_ACC_D;
      S_ACC_D:     state_d = S_SAT;
      S_SAT:       state_d = S_DONE;
      S_DONE:      state_d = load_out ? S_IDLE : S_DONE;
      default:     state_d = S_IDLE;
    endcase
  end

  // output valid next value
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_DONE && load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // control state, configuration and filter/PID state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      gyro_zero_q  <= GYRO_ZERO_RESET;
      accel_gain_q <= UNITY_GAIN;
      gyro_gain_q  <= UNITY_GAIN;
      blend_gain_q <= UNITY_GAIN;
      setpoint_q   <= '0;
      kp_q         <= '0;
      ki_q         <= '0;
      kd_q         <= '0;
      integral_q   <= INTEGRAL_RESET;
      kp_l_q       <= '0;
      ki_l_q       <= '0;
      kd_l_q       <= '0;
      e1_q         <= '0;
      e2_q         <= '0;
      drive_last_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GYRO_ZERO:  gyro_zero_q  <= cfg_wdata_i[15:0];
          CFG_ACCEL_GAIN: accel_gain_q <= cfg_wdata_i;
          CFG_GYRO_GAIN:  gyro_gain_q  <= cfg_wdata_i;
          CFG_BLEND_GAIN: blend_gain_q <= cfg_wdata_i;
          CFG_SETPOINT:   setpoint_q   <= cfg_wdata_i[15:0];
          CFG_KP:         kp_q         <= cfg_wdata_i;
          CFG_KI:         ki_q         <= cfg_wdata_i;
          CFG_KD:         kd_q         <= cfg_wdata_i;
          default:        ;
        endcase
      end

      // PID reset item: latch gains, clear history
      if (in_accept && in_if.operation == OP_RESET_PID) begin
        kp_l_q       <= kp_q;
        ki_l_q       <= ki_q;
        kd_l_q       <= kd_q;
        e1_q         <= '0;
        e2_q         <= '0;
        drive_last_q <= '0;
      end

      // align loads the integral from the accelerometer angle
      if (state_q == S_ANGLE && op_q == OP_ALIGN) begin
        integral_q <= sat32(prod_q);
      end

      if (state_q == S_UPDATE) begin
        integral_q <= sat32(64'(34'(integral_q) + 34'(rate_q) + 34'(blend_q)));
      end

      if (state_q == S_SAT) begin
        e2_q         <= e1_q;
        e1_q         <= err_q;
        drive_last_q <= drive_sat;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;

    if (in_accept) begin
      op_q    <= op_e'(in_if.operation);
      accel_q <= in_if.accel_sample;
      gyro_q  <= in_if.gyro_sample;
      unique case (op_e'(in_if.operation))
        OP_RESET_PID: begin
          res_drive_q <= '0;
          res_tilt_q  <= integral_q;
          res_err_q   <= '0;
        end
        OP_HOLD: begin
          res_drive_q <= drive_last_q;
          res_tilt_q  <= integral_q;
          res_err_q   <= '0;
        end
        default: begin
          res_drive_q <= drive_last_q;
          res_tilt_q  <= integral_q;
          res_err_q   <= '0;
        end
      endcase
    end

    case (state_q)
      S_ANGLE: begin
        accel_angle_q <= sat32(prod_q);
        if (op_q == OP_ALIGN) begin
          res_tilt_q <= sat32(prod_q);
        end
      end
      S_DIFF: begin
        rate_q     <= sat32(prod_q);
        diff_q     <= sat32(64'(33'(accel_angle_q) - 33'(integral_q)));
        err_q      <= err_new;
        res_tilt_q <= integral_q;
      end
      S_BLEND: begin
        blend_q <= sat32(prod_q >>> 16);
      end
      S_UPDATE: begin
        acc_q <= AccW'(drive_last_q) + AccW'(prod_q);
      end
      S_ACC_I, S_ACC_D: begin
        acc_q <= acc_q + AccW'(prod_q);
      end
      S_SAT: begin
        res_drive_q <= drive_sat;
        res_err_q   <= 32'(err_q);
      end
      default: ;
    endcase

    if (state_q == S_DONE && load_out) begin
      out_drive_q <= res_drive_q;
      out_tilt_q  <= res_tilt_q;
      out_err_q   <= res_err_q;
    end
  end

  // checks
  `TEP_ASSERT_NXT(a_busy_after_accept, in_accept, !in_if.ready, "accepted item did not start")
  `TEP_ASSERT_NXT(a_out_drain,
                  out_if.valid && out_if.ready && state_q != S_DONE,
                  !out_if.valid, "result not retired after take")
  `TEP_ASSERT_IMP(a_err_range, out_if.valid,
                  $countones(out_if.angle_error[31:17]) == 0 ||
                  $countones(out_if.angle_error[31:17]) == 15,
                  "angle error outside 18-bit range")
  `TEP_ASSERT_NXT(a_pid_clear, in_accept && in_if.operation == OP_RESET_PID,
                  drive_last_q == '0 && e1_q == '0 && e2_q == '0, "PID history not cleared")

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for tilt_estimate_and_pid: random and directed items, checked against a local predictor
`timescale 1ns / 1ps

module tb;
  import tep_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  // One expected or observed result item
  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] tilt;
    logic signed [31:0] err;
  } tilt_result_t;

  // Tilt filter and PID predictor plus the queue of expected result items
  class tilt_scoreboard;
    tilt_result_t       pending[$];
    int unsigned        mismatches;
    int unsigned        checked;
    logic [15:0]        gyro_zero;
    logic signed [15:0] setpoint;
    logic signed [31:0] accel_gain, gyro_gain, blend_gain, kp, ki, kd;
    logic signed [31:0] integral, err_last, err_prev, drive_last;
    longint             coef0, coef1, coef2;

    function new();
      gyro_zero  = GYRO_ZERO_RESET;
      accel_gain = UNITY_GAIN;
      gyro_gain  = UNITY_GAIN;
      blend_gain = UNITY_GAIN;
      setpoint   = '0;
      kp         = '0;
      ki         = '0;
      kd         = '0;
      integral   = INTEGRAL_RESET;
      mismatches = 0;
      checked    = 0;
      latch_gains();
    endfunction

    function logic signed [31:0] clamp32(longint x);
      if (x > 64'sd2147483647) begin
        return 32'sh7fff_ffff;
      end
      if (x < -64'sd2147483648) begin
        return 32'sh8000_0000;
      end
      return 32'(x);
    endfunction

    // PID gains only take effect here; history is cleared too
    function void latch_gains();
      coef0      = longint'(kp) + longint'(ki) + longint'(kd);
      coef1      = -longint'(kp) - 2 * longint'(kd);
      coef2      = longint'(kd);
      err_last   = '0;
      err_prev   = '0;
      drive_last = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] data);
      case (idx)
        CFG_GYRO_ZERO:  gyro_zero  = data[15:0];
        CFG_ACCEL_GAIN: accel_gain = data;
        CFG_GYRO_GAIN:  gyro_gain  = data;
        CFG_BLEND_GAIN: blend_gain = data;
        CFG_SETPOINT:   setpoint   = data[15:0];
        CFG_KP:         kp         = data;
        CFG_KI:         ki         = data;
        CFG_KD:         kd         = data;
        default: ;
      endcase
    endfunction

    // Work out the result of one accepted input item
    function void note_item(op_e op, logic [15:0] accel, logic [15:0] gyro);
      logic signed [31:0] accel_angle, rate, diff, blend;
      longint             whole;
      tilt_result_t       exp_r;
      accel_angle = clamp32((longint'(accel) - longint'(ACCEL_OFFSET)) * longint'(accel_gain));
      exp_r.drive = drive_last;
      exp_r.tilt  = integral;
      exp_r.err   = '0;
      case (op)
        OP_STEP: begin
          rate  = clamp32((longint'(gyro_zero) - longint'(gyro)) * longint'(gyro_gain));
          diff  = clamp32(longint'(accel_angle) - longint'(integral));
          blend = clamp32((longint'(diff) * longint'(blend_gain)) >>> 16);
          // integer part of the old estimate, rounded toward zero
          whole = longint'(integral) / 64'sd65536;
          exp_r.err = clamp32(whole - longint'(setpoint));
          integral = clamp32(longint'(integral) + longint'(rate) + longint'(blend));
          exp_r.drive = clamp32(longint'(drive_last) + coef0 * longint'(exp_r.err)
                                + coef1 * longint'(err_last) + coef2 * longint'(err_prev));
          err_prev   = err_last;
          err_last   = exp_r.err;
          drive_last = exp_r.drive;
        end
        OP_RESET_PID: begin
          latch_gains();
          exp_r.drive = '0;
        end
        OP_ALIGN: begin
          integral   = accel_angle;
          exp_r.tilt = accel_angle;
        end
        default: ;
      endcase
      pending.push_back(exp_r);
    endfunction

    // Compare one accepted result item with the oldest expectation
    function void check_result(logic signed [31:0] drive, logic signed [31:0] tilt,
                               logic signed [31:0] err);
      tilt_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result item: drive %0d tilt_angle %0d angle_error %0d",
               drive, tilt, err);
        mismatches++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (drive !== exp_r.drive) begin
        $error("drive: expected %0d, got %0d", exp_r.drive, drive);
        mismatches++;
      end
      if (tilt !== exp_r.tilt) begin
        $error("tilt_angle: expected %0d, got %0d", exp_r.tilt, tilt);
        mismatches++;
      end
      if (err !== exp_r.err) begin
        $error("angle_error: expected %0d, got %0d", exp_r.err, err);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  tep_in_if  in_ch ();
  tep_out_if out_ch ();

  tilt_estimate_and_pid i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  tilt_scoreboard sb;
  logic [31:0]    setting [8];
  bit             in_calm;
  bit             out_calm;
  int unsigned    items_sent;
  int unsigned    settings_applied;
  int unsigned    quiet_cycles;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog: too long without any item moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      1:       return 16'(32768 + $urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1:       return $urandom;
      default: return $urandom_range(0, 262144) - 32'd131072;
    endcase
  endfunction

  // Register write, mirrored into the scoreboard
  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic write_setting();
    for (int i = 0; i < 8; i++) begin
      write_reg(cfg_idx_e'(i), setting[i]);
    end
    settings_applied++;
  endtask

  // Offer one input item after a random gap and wait for it to be taken
  task automatic send_item(op_e op, logic [15:0] accel, logic [15:0] gyro);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) begin
      in_calm = !in_calm;
    end
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.accel_sample <= accel;
    in_ch.gyro_sample  <= gyro;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_item(op, accel, gyro);
    items_sent++;
  endtask

  // Hold off until every outstanding result item has come back
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Result side: random stalls, calm stretches
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        out_calm = !out_calm;
      end
      stall = out_calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      sb.check_result(out_ch.drive, out_ch.tilt_angle, out_ch.angle_error);
    end
  end

  // Stimulus
  initial begin
    int unsigned r;
    op_e         op;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_STEP;
    in_ch.accel_sample <= '0;
    in_ch.gyro_sample  <= '0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_GYRO_ZERO;
    cfg_wdata_i        <= '0;
    rst_ni             <= 1'b0;
    quiet_cycles     = 0;
    items_sent       = 0;
    settings_applied = 0;
    in_calm          = 1'b0;
    out_calm         = 1'b0;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: every operation, sample extremes, rate saturation
    send_item(OP_STEP, 16'd32768, 16'd32768);
    send_item(OP_HOLD, 16'h0000, 16'h0000);
    send_item(OP_ALIGN, 16'h0000, 16'h0000);
    send_item(OP_ALIGN, 16'hffff, 16'hffff);
    send_item(OP_STEP, 16'hffff, 16'h0000);
    send_item(OP_STEP, 16'h0000, 16'hffff);
    send_item(OP_RESET_PID, 16'h5a5a, 16'ha5a5);
    wait_results();

    // Largest PID gains; the first step must still use the old latched gains
    setting[CFG_GYRO_ZERO]  = 32'd32768;
    setting[CFG_ACCEL_GAIN] = 32'd65536;
    setting[CFG_GYRO_GAIN]  = 32'd65536;
    setting[CFG_BLEND_GAIN] = 32'd65536;
    setting[CFG_SETPOINT]   = 32'h0000_8000;
    setting[CFG_KP]         = 32'h7fff_ffff;
    setting[CFG_KI]         = 32'h7fff_ffff;
    setting[CFG_KD]         = 32'h7fff_ffff;
    write_setting();
    send_item(OP_STEP, 16'd32768, 16'd32768);
    send_item(OP_RESET_PID, 16'h0000, 16'h0000);
    send_item(OP_STEP, 16'hffff, 16'h0000);
    send_item(OP_STEP, 16'hffff, 16'h0000);
    send_item(OP_STEP, 16'd40000, 16'd20000);
    send_item(OP_ALIGN, 16'h0000, 16'h0000);
    send_item(OP_STEP, 16'h0000, 16'hffff);
    wait_results();

    // Most negative gains everywhere, zero gyro offset
    setting[CFG_GYRO_ZERO]  = 32'hffff_0000;
    setting[CFG_ACCEL_GAIN] = 32'h8000_0000;
    setting[CFG_GYRO_GAIN]  = 32'h8000_0000;
    setting[CFG_BLEND_GAIN] = 32'h8000_0000;
    setting[CFG_SETPOINT]   = 32'h0000_7fff;
    setting[CFG_KP]         = 32'h8000_0000;
    setting[CFG_KI]         = 32'h8000_0000;
    setting[CFG_KD]         = 32'h8000_0000;
    write_setting();
    send_item(OP_RESET_PID, 16'hffff, 16'hffff);
    send_item(OP_STEP, 16'h0000, 16'hffff);
    send_item(OP_STEP, 16'hffff, 16'h0000);
    send_item(OP_STEP, 16'd32768, 16'h0000);
    send_item(OP_ALIGN, 16'hffff, 16'h0000);
    send_item(OP_HOLD, 16'd12345, 16'd54321);
    send_item(OP_STEP, 16'h0001, 16'h0001);
    wait_results();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 11) begin
        setting[CFG_GYRO_ZERO]  = 32'hffff_ffff;
        setting[CFG_ACCEL_GAIN] = 32'd65536;
        setting[CFG_GYRO_GAIN]  = 32'd65536;
        setting[CFG_BLEND_GAIN] = 32'd65536;
        setting[CFG_SETPOINT]   = 32'd0;
        setting[CFG_KP]         = 32'd65536;
        setting[CFG_KI]         = 32'd6554;
        setting[CFG_KD]         = 32'd0;
      end else begin
        setting[CFG_GYRO_ZERO]  = {16'($urandom), rand_sample()};
        setting[CFG_ACCEL_GAIN] = rand_gain();
        setting[CFG_GYRO_GAIN]  = rand_gain();
        setting[CFG_BLEND_GAIN] = rand_gain();
        setting[CFG_SETPOINT]   = $urandom;
        setting[CFG_KP]         = rand_gain();
        setting[CFG_KI]         = rand_gain();
        setting[CFG_KD]         = rand_gain();
      end
      write_setting();
      send_item(OP_RESET_PID, rand_sample(), rand_sample());
      repeat (64) begin
        r = $urandom_range(0, 19);
        if (r < 14) begin
          op = OP_STEP;
        end else if (r < 16) begin
          op = OP_RESET_PID;
        end else if (r < 18) begin
          op = OP_ALIGN;
        end else begin
          op = OP_HOLD;
        end
        send_item(op, rand_sample(), rand_sample());
      end
      wait_results();
    end

    repeat (16) @(posedge clk_i);
    $display("Sent %0d items under %0d register settings; %0d results checked, %0d mismatches.",
             items_sent, settings_applied, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tep_pkg.sv
hw/rtl/tep_if.sv
hw/rtl/tilt_estimate_and_pid.sv
tb/sv/tb.sv
